// ----- sv/tas_pkg.sv -----
// shared types, constants and step table of the timed actuator sequencer
package tas_pkg;

	localparam int MODE_W  = 3;
	localparam int STEP_W  = 4;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int NUM_SEQ = 5;

	localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LARGE    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SMALL    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PREP     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CATCH    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_EXCHANGE = 3'd5;

	localparam logic [2:0] SEQ_LARGE    = 3'd0;
	localparam logic [2:0] SEQ_SMALL    = 3'd1;
	localparam logic [2:0] SEQ_PREP     = 3'd2;
	localparam logic [2:0] SEQ_CATCH    = 3'd3;
	localparam logic [2:0] SEQ_EXCHANGE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GATE  = 2'd3;

	localparam logic [CFG_W-1:0] SHORT_RESET = 16'd300;
	localparam logic [CFG_W-1:0] LONG_RESET  = 16'd800;
	localparam logic [CFG_W-1:0] END_RESET   = 16'd100;
	localparam logic [CFG_W-1:0] GATE_RESET  = 16'd25;

	localparam logic [7:0] ACT_NONE     = 8'h00;
	localparam logic [7:0] ACT_CLAMP    = 8'h01;
	localparam logic [7:0] ACT_LIFT1    = 8'h06;
	localparam logic [7:0] ACT_LIFT1_L1 = 8'h02;
	localparam logic [7:0] ACT_LIFT1_L2 = 8'h04;
	localparam logic [7:0] ACT_LIFT2    = 8'h18;
	localparam logic [7:0] ACT_LIFT2_L1 = 8'h08;
	localparam logic [7:0] ACT_LIFT2_L2 = 8'h10;
	localparam logic [7:0] ACT_FWD      = 8'h20;
	localparam logic [7:0] ACT_MID      = 8'h40;
	localparam logic [7:0] ACT_EXCH     = 8'h80;

	typedef enum logic [1:0] {
		DLY_SHORT = 2'd0,
		DLY_LONG  = 2'd1,
		DLY_END   = 2'd2,
		DLY_GATE  = 2'd3
	} dly_kind_t;

	typedef struct packed {
		logic [7:0] mask;
		logic [7:0] val;
		dly_kind_t  dly;
	} step_act_t;

	typedef struct packed {
		logic running;
		logic expire;
	} tmr_status_t;

	function automatic step_act_t mk(input logic [7:0] mask, input logic [7:0] val,
			input dly_kind_t dly);
		step_act_t a;
		a.mask = mask;
		a.val  = val;
		a.dly  = dly;
		return a;
	endfunction

	function automatic step_act_t step_act(input logic [2:0] seq, input logic [STEP_W-1:0] k);
		step_act_t a;
		a = mk(ACT_NONE, ACT_NONE, DLY_SHORT);
		case (seq)
			SEQ_LARGE: begin
				case (k)
					4'd1: a = mk(ACT_CLAMP, ACT_NONE, DLY_SHORT);
					4'd2: a = mk(ACT_LIFT1, ACT_LIFT1_L2, DLY_LONG);
					4'd3: a = mk(ACT_FWD, ACT_FWD, DLY_SHORT);
					4'd4: a = mk(ACT_CLAMP, ACT_CLAMP, DLY_SHORT);
					4'd5: a = mk(ACT_LIFT2, ACT_LIFT2_L1, DLY_LONG);
					4'd6: a = mk(ACT_FWD, ACT_NONE, DLY_SHORT);
					4'd7: a = mk(ACT_LIFT1, ACT_NONE, DLY_LONG);
					4'd8: a = mk(ACT_LIFT2, ACT_NONE, DLY_LONG);
					4'd9: a = mk(ACT_CLAMP, ACT_NONE, DLY_SHORT);
					default: a = mk(ACT_NONE, ACT_NONE, DLY_SHORT);
				endcase
			end
			SEQ_SMALL: begin
				case (k)
					4'd1:  a = mk(ACT_CLAMP, ACT_NONE, DLY_SHORT);
					4'd2:  a = mk(ACT_LIFT2, ACT_LIFT2_L1, DLY_LONG);
					4'd3:  a = mk(ACT_LIFT1, ACT_LIFT1_L1, DLY_LONG);
					4'd4:  a = mk(ACT_FWD, ACT_FWD, DLY_SHORT);
					4'd5:  a = mk(ACT_CLAMP, ACT_CLAMP, DLY_SHORT);
					4'd6:  a = mk(ACT_MID, ACT_MID, DLY_SHORT);
					4'd7:  a = mk(ACT_LIFT1, ACT_NONE, DLY_LONG);
					4'd8:  a = mk(ACT_FWD, ACT_NONE, DLY_SHORT);
					4'd9:  a = mk(ACT_MID, ACT_NONE, DLY_SHORT);
					4'd10: a = mk(ACT_LIFT2, ACT_NONE, DLY_LONG);
					4'd11: a = mk(ACT_CLAMP, ACT_NONE, DLY_SHORT);
					default: a = mk(ACT_NONE, ACT_NONE, DLY_SHORT);
				endcase
			end
			SEQ_PREP: begin
				case (k)
					4'd1: a = mk(ACT_CLAMP, ACT_NONE, DLY_END);
					4'd2: a = mk(ACT_LIFT2, ACT_LIFT2_L1, DLY_LONG);
					4'd3: a = mk(ACT_LIFT1, ACT_LIFT1_L2, DLY_LONG);
					4'd4: a = mk(ACT_FWD, ACT_FWD, DLY_SHORT);
					4'd5: a = mk(ACT_MID, ACT_MID, DLY_SHORT);
					default: a = mk(ACT_NONE, ACT_NONE, DLY_SHORT);
				endcase
			end
			SEQ_CATCH: begin
				case (k)
					4'd1: a = mk(ACT_NONE, ACT_NONE, DLY_GATE);
					4'd2: a = mk(ACT_CLAMP, ACT_CLAMP, DLY_SHORT);
					4'd3: a = mk(ACT_FWD, ACT_NONE, DLY_SHORT);
					4'd4: a = mk(ACT_LIFT1, ACT_NONE, DLY_LONG);
					4'd5: a = mk(ACT_MID, ACT_NONE, DLY_SHORT);
					4'd6: a = mk(ACT_LIFT2, ACT_NONE, DLY_LONG);
					4'd7: a = mk(ACT_CLAMP, ACT_NONE, DLY_SHORT);
					default: a = mk(ACT_NONE, ACT_NONE, DLY_SHORT);
				endcase
			end
			SEQ_EXCHANGE: begin
				case (k)
					4'd1: a = mk(ACT_CLAMP, ACT_CLAMP, DLY_SHORT);
					4'd2: a = mk(ACT_LIFT2, ACT_LIFT2_L2, DLY_LONG);
					4'd3: a = mk(ACT_LIFT1, ACT_LIFT1_L1, DLY_LONG);
					4'd4: a = mk(ACT_FWD, ACT_FWD, DLY_SHORT);
					4'd5: a = mk(ACT_CLAMP, ACT_NONE, DLY_SHORT);
					4'd6: a = mk(ACT_EXCH, ACT_EXCH, DLY_SHORT);
					4'd7: a = mk(ACT_EXCH | ACT_FWD, ACT_NONE, DLY_SHORT);
					4'd8: a = mk(ACT_LIFT1, ACT_NONE, DLY_LONG);
					4'd9: a = mk(ACT_LIFT2, ACT_NONE, DLY_LONG);
					default: a = mk(ACT_NONE, ACT_NONE, DLY_SHORT);
				endcase
			end
			default: a = mk(ACT_NONE, ACT_NONE, DLY_SHORT);
		endcase
		return a;
	endfunction

	function automatic logic [STEP_W-1:0] end_step(input logic [2:0] seq);
		logic [STEP_W-1:0] e;
		case (seq)
			SEQ_LARGE:    e = 4'd10;
			SEQ_SMALL:    e = 4'd12;
			SEQ_PREP:     e = 4'd6;
			SEQ_CATCH:    e = 4'd8;
			SEQ_EXCHANGE: e = 4'd10;
			default:      e = 4'd0;
		endcase
		return e;
	endfunction

	function automatic logic [MODE_W-1:0] end_mode(input logic [2:0] seq);
		logic [MODE_W-1:0] m;
		case (seq)
			SEQ_PREP: m = MODE_CATCH;
			default:  m = MODE_IDLE;
		endcase
		return m;
	endfunction

endpackage

// ----- sv/tas_if.sv -----
// tick input and actuator result channel interfaces
interface tas_in_if;
	logic                       valid;
	logic                       ready;
	logic                       mode_write;
	logic [tas_pkg::MODE_W-1:0] mode_value;
	logic                       photogate;

	modport source (output valid, output mode_write, output mode_value, output photogate,
		input ready);
	modport sink (input valid, input mode_write, input mode_value, input photogate,
		output ready);
endinterface

interface tas_out_if;
	logic                       valid;
	logic                       ready;
	logic                       clamp_on;
	logic [1:0]                 lift_once_level;
	logic [1:0]                 lift_twice_level;
	logic                       forward_on;
	logic                       midair_on;
	logic                       exchange_on;
	logic [tas_pkg::MODE_W-1:0] active_mode;
	logic [tas_pkg::STEP_W-1:0] active_step;
	logic                       delay_pending;

	modport source (output valid, output clamp_on, output lift_once_level,
		output lift_twice_level, output forward_on, output midair_on, output exchange_on,
		output active_mode, output active_step, output delay_pending, input ready);
	modport sink (input valid, input clamp_on, input lift_once_level,
		input lift_twice_level, input forward_on, input midair_on, input exchange_on,
		input active_mode, input active_step, input delay_pending, output ready);
endinterface

// ----- sv/tas_delay_timer.sv -----
// shared step delay counter with saturating target and elapsed count
module tas_delay_timer #(
	parameter int DELAY_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic                      req,
	input  logic [tas_pkg::CFG_W-1:0] req_ticks,
	output tas_pkg::tmr_status_t      status
);

	localparam int WIDE = (DELAY_WIDTH > tas_pkg::CFG_W) ? DELAY_WIDTH : tas_pkg::CFG_W;
	localparam logic [WIDE-1:0] MAX_WIDE = WIDE'({DELAY_WIDTH{1'b1}});
	localparam logic [DELAY_WIDTH-1:0] MAX_CNT = {DELAY_WIDTH{1'b1}};

	logic                   running_q;
	logic [DELAY_WIDTH-1:0] target_q;
	logic [DELAY_WIDTH-1:0] elapsed_q;
	logic [DELAY_WIDTH-1:0] elapsed_inc;
	logic [WIDE-1:0]        ticks_wide;
	logic [WIDE-1:0]        ticks_sat;

	assign elapsed_inc = (elapsed_q == MAX_CNT) ? elapsed_q : elapsed_q + 1'b1;
	assign ticks_wide  = WIDE'(req_ticks);
	assign ticks_sat   = (ticks_wide > MAX_WIDE) ? MAX_WIDE : ticks_wide;

	assign status.running = running_q;
	assign status.expire  = running_q && (elapsed_inc >= target_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			target_q  <= '0;
			elapsed_q <= '0;
		end else if (advance) begin
			if (req) begin
				running_q <= 1'b1;
				target_q  <= ticks_sat[DELAY_WIDTH-1:0];
				elapsed_q <= '0;
			end else if (running_q) begin
				elapsed_q <= elapsed_inc;
				if (status.expire) begin
					running_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- sv/timed_actuator_sequencer.sv -----
// top level of the timed actuator sequencer: tick register, sequence step logic, result register
//
// channel  | role   | handshake          | payload
// in_ch    | sink   | valid/ready        | mode_write, mode_value, photogate (one tick)
// out_ch   | source | valid/ready        | actuator levels, active_mode, active_step,
//          |        |                    | delay_pending (one result per tick)
// cfg      | write  | cfg_we, cfg_index  | cfg_data, four delay registers
//
// one transaction per cycle sustained unless out_ch stalls; each result is registered
// the tick register and the result register each hold one transaction, all state updates
// happen as a tick moves from the tick register into the result register
// a stalled result holds the tick register, which then holds in_ch.ready low
// arst_n clears the mode, all step indexes, the delay counter and the actuators,
// and restores the delay registers to 300, 800, 100 and 25 ticks
module timed_actuator_sequencer #(
	parameter int DELAY_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tas_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tas_pkg::CFG_W-1:0]     cfg_data,
	tas_in_if.sink                        in_ch,
	tas_out_if.source                     out_ch
);

	localparam int NSEQ = tas_pkg::NUM_SEQ;

	// configuration
	logic [tas_pkg::CFG_W-1:0] short_q, long_q, end_q, gate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= tas_pkg::SHORT_RESET;
			long_q  <= tas_pkg::LONG_RESET;
			end_q   <= tas_pkg::END_RESET;
			gate_q  <= tas_pkg::GATE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tas_pkg::CFG_SHORT: short_q <= cfg_data;
				tas_pkg::CFG_LONG:  long_q  <= cfg_data;
				tas_pkg::CFG_END:   end_q   <= cfg_data;
				tas_pkg::CFG_GATE:  gate_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// tick register
	logic                       valid_s1;
	logic                       mode_write_s1;
	logic [tas_pkg::MODE_W-1:0] mode_value_s1;
	logic                       photogate_s1;
	logic                       valid_s2;
	logic                       advance;
	logic                       in_fire;

	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_fire     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_write_s1 <= in_ch.mode_write;
			mode_value_s1 <= in_ch.mode_value;
			photogate_s1  <= in_ch.photogate;
		end
	end

	// sequence state
	logic [tas_pkg::MODE_W-1:0] mode_q;
	logic [tas_pkg::MODE_W-1:0] mode_before_q;
	logic [tas_pkg::STEP_W-1:0] cur_q  [NSEQ];
	logic [tas_pkg::STEP_W-1:0] next_q [NSEQ];
	logic [7:0]                 act_q;

	tas_pkg::tmr_status_t      tstat;
	logic                      accepting;
	logic                      req;
	tas_pkg::dly_kind_t        req_kind;
	logic [tas_pkg::CFG_W-1:0] req_ticks;

	logic [tas_pkg::MODE_W-1:0] mode_w;
	logic [tas_pkg::MODE_W-1:0] mode_f;
	logic [tas_pkg::MODE_W-1:0] end_md;
	logic                       end_hit;
	logic                       changed;
	logic [tas_pkg::STEP_W-1:0] cur_b  [NSEQ];
	logic [tas_pkg::STEP_W-1:0] next_b [NSEQ];
	logic [tas_pkg::STEP_W-1:0] cur_f  [NSEQ];
	logic [tas_pkg::STEP_W-1:0] next_f [NSEQ];
	logic [tas_pkg::STEP_W-1:0] k;
	logic [tas_pkg::STEP_W-1:0] k_end;
	tas_pkg::step_act_t         a;
	logic [7:0]                 act_mask;
	logic [7:0]                 act_val;
	logic [7:0]                 act_f;
	logic [tas_pkg::STEP_W-1:0] step_out;

	assign accepting = !tstat.running || tstat.expire;

	always_comb begin
		mode_w = mode_q;
		if (mode_write_s1 && (mode_value_s1 <= tas_pkg::MODE_EXCHANGE)) begin
			mode_w = mode_value_s1;
		end
		changed  = (mode_w != mode_before_q);
		act_mask = '0;
		act_val  = '0;
		req      = 1'b0;
		req_kind = tas_pkg::DLY_SHORT;
		end_hit  = 1'b0;
		end_md   = tas_pkg::MODE_IDLE;
		k        = '0;
		k_end    = '0;
		a        = tas_pkg::mk(tas_pkg::ACT_NONE, tas_pkg::ACT_NONE, tas_pkg::DLY_SHORT);
		for (int s = 0; s < NSEQ; s++) begin
			// expiry commits, then a mode change clears every sequence
			cur_b[s]  = tstat.expire ? next_q[s] : cur_q[s];
			next_b[s] = next_q[s];
			if (changed) begin
				cur_b[s]  = '0;
				next_b[s] = '0;
			end
			cur_f[s]  = cur_b[s];
			next_f[s] = next_b[s];
			if (mode_w == tas_pkg::MODE_W'(s + 1)) begin
				k     = cur_b[s];
				k_end = tas_pkg::end_step(3'(s));
				a     = tas_pkg::step_act(3'(s), k);
				if (k == '0) begin
					cur_f[s]  = tas_pkg::STEP_W'(1);
					next_f[s] = tas_pkg::STEP_W'(1);
				end else if (k < k_end) begin
					next_f[s] = k + 1'b1;
					act_mask  = a.mask;
					act_val   = a.val;
					if ((a.dly != tas_pkg::DLY_GATE) || photogate_s1) begin
						req      = accepting;
						req_kind = a.dly;
					end
				end else if (k == k_end) begin
					next_f[s] = '0;
					end_hit   = 1'b1;
					end_md    = tas_pkg::end_mode(3'(s));
					if (end_md == tas_pkg::MODE_IDLE) begin
						req      = accepting;
						req_kind = tas_pkg::DLY_END;
					end
				end else begin
					cur_f[s]  = '0;
					next_f[s] = '0;
				end
			end
		end
		mode_f = end_hit ? end_md : mode_w;
		act_f  = (act_q & ~act_mask) | act_val;
		step_out = '0;
		for (int s = 0; s < NSEQ; s++) begin
			if (mode_f == tas_pkg::MODE_W'(s + 1)) begin
				step_out = cur_f[s];
			end
		end
	end

	always_comb begin
		case (req_kind)
			tas_pkg::DLY_SHORT: req_ticks = short_q;
			tas_pkg::DLY_LONG:  req_ticks = long_q;
			tas_pkg::DLY_END:   req_ticks = end_q;
			tas_pkg::DLY_GATE:  req_ticks = gate_q;
			default:            req_ticks = short_q;
		endcase
	end

	tas_delay_timer #(
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_timer (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.req       (req),
		.req_ticks (req_ticks),
		.status    (tstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= tas_pkg::MODE_IDLE;
			mode_before_q <= tas_pkg::MODE_IDLE;
			act_q         <= '0;
			for (int s = 0; s < NSEQ; s++) begin
				cur_q[s]  <= '0;
				next_q[s] <= '0;
			end
		end else if (advance) begin
			mode_q        <= mode_f;
			mode_before_q <= mode_w;
			act_q         <= act_f;
			for (int s = 0; s < NSEQ; s++) begin
				cur_q[s]  <= cur_f[s];
				next_q[s] <= next_f[s];
			end
		end
	end

	// result register
	logic [7:0]                 act_s2;
	logic [tas_pkg::MODE_W-1:0] mode_s2;
	logic [tas_pkg::STEP_W-1:0] step_s2;
	logic                       pending_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= advance || (valid_s2 && !out_ch.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			act_s2     <= act_f;
			mode_s2    <= mode_f;
			step_s2    <= step_out;
			pending_s2 <= req || (tstat.running && !tstat.expire);
		end
	end

	assign out_ch.valid            = valid_s2;
	assign out_ch.clamp_on         = act_s2[0];
	assign out_ch.lift_once_level  = act_s2[2:1];
	assign out_ch.lift_twice_level = act_s2[4:3];
	assign out_ch.forward_on       = act_s2[5];
	assign out_ch.midair_on        = act_s2[6];
	assign out_ch.exchange_on      = act_s2[7];
	assign out_ch.active_mode      = mode_s2;
	assign out_ch.active_step      = step_s2;
	assign out_ch.delay_pending    = pending_s2;

	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (valid_s1 && valid_s2 && !out_ch.ready))
		else $error("tick register blocked while result path is free");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(mode_q) && $stable(act_q) && $stable(mode_before_q)))
		else $error("sequence state moved without a tick");

	a_idle_step_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (out_ch.active_mode == tas_pkg::MODE_IDLE)) |-> (out_ch.active_step == '0))
		else $error("idle mode reports a nonzero step");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("processed tick produced no result");

endmodule

// ----- verif/timed_actuator_sequencer_test.sv -----
// testbench for the timed actuator sequencer: directed table, random sequences, tick-order check
`timescale 1ns / 100ps

module timed_actuator_sequencer_test;
	import tas_pkg::*;

	localparam int          CYCLE_LIMIT = 200000;
	localparam logic [15:0] DLY_MAX     = 16'hFFFF;
	localparam logic [2:0]  MODE_BAD_LO = 3'd6;
	localparam logic [2:0]  MODE_BAD_HI = 3'd7;

	typedef struct packed {
		logic       exch;
		logic       mid;
		logic       fwd;
		logic [1:0] lift2;
		logic [1:0] lift1;
		logic       clamp;
		logic [2:0] mode;
		logic [3:0] step;
		logic       pend;
	} tick_result_t;

	typedef enum logic [1:0] {
		ROW_TICK  = 2'd0,
		ROW_FIXED = 2'd1,
		ROW_CFG   = 2'd2
	} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		logic         mw;
		logic [2:0]   mv;
		logic         pg;
		tick_result_t res;
		logic [1:0]   idx;
		logic [15:0]  data;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	tas_in_if  in_ch ();
	tas_out_if out_ch ();

	timed_actuator_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// sequencer state mirror
	logic [15:0] short_ticks = SHORT_RESET;
	logic [15:0] long_ticks  = LONG_RESET;
	logic [15:0] end_ticks   = END_RESET;
	logic [15:0] gate_ticks  = GATE_RESET;
	logic [2:0]  mode_now    = MODE_IDLE;
	logic [2:0]  mode_before = MODE_IDLE;
	logic [3:0]  step_cur [0:NUM_SEQ-1];
	logic [3:0]  step_nxt [0:NUM_SEQ-1];
	logic        dly_run     = 1'b0;
	logic        dly_acc     = 1'b1;
	logic [15:0] dly_target  = '0;
	logic [15:0] dly_elapsed = '0;
	logic [7:0]  act_bits    = ACT_NONE;

	tick_result_t tick_results [$];
	row_t         plan [$];
	int           mismatches  = 0;
	int           ticks_sent  = 0;
	int           hold_cycles = 0;
	int           cycle_count = 0;
	bit           no_idle     = 1'b0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed_actuator_sequencer_test NOT OK");
			$finish;
		end
	end

	task automatic arm_delay(input logic [15:0] t);
		if (dly_acc) begin
			dly_acc     = 1'b0;
			dly_target  = t;
			dly_elapsed = '0;
			dly_run     = 1'b1;
		end
	endtask

	task automatic step_sequences(input logic mw, input logic [2:0] mv, input logic pg,
			output tick_result_t r);
		int          i;
		logic [2:0]  s;
		logic [3:0]  k;
		logic [3:0]  last_k;
		logic [7:0]  mask;
		logic [7:0]  val;
		logic [1:0]  kind;
		logic [15:0] t;
		logic [3:0]  shown;
		if (mw && mv <= MODE_EXCHANGE)
			mode_now = mv;
		if (dly_run) begin
			if (dly_elapsed < DLY_MAX)
				dly_elapsed = dly_elapsed + 1'b1;
			if (dly_elapsed >= dly_target) begin
				for (i = 0; i < NUM_SEQ; i++)
					step_cur[i] = step_nxt[i];
				dly_acc = 1'b1;
				dly_run = 1'b0;
			end
		end
		if (mode_now != mode_before) begin
			for (i = 0; i < NUM_SEQ; i++) begin
				step_cur[i] = '0;
				step_nxt[i] = '0;
			end
		end
		mode_before = mode_now;
		if (mode_now != MODE_IDLE) begin
			s = mode_now - 1'b1;
			k = step_cur[s];
			case (s)
				SEQ_LARGE:    last_k = 4'd10;
				SEQ_SMALL:    last_k = 4'd12;
				SEQ_PREP:     last_k = 4'd6;
				SEQ_CATCH:    last_k = 4'd8;
				default:      last_k = 4'd10;
			endcase
			if (k == 4'd0) begin
				step_nxt[s] = 4'd1;
				step_cur[s] = 4'd1;
			end else if (k < last_k) begin
				case ({s, k})
					{SEQ_LARGE, 4'd1}:     {mask, val, kind} = {ACT_CLAMP, ACT_NONE, DLY_SHORT};
					{SEQ_LARGE, 4'd2}:     {mask, val, kind} = {ACT_LIFT1, ACT_LIFT1_L2, DLY_LONG};
					{SEQ_LARGE, 4'd3}:     {mask, val, kind} = {ACT_FWD, ACT_FWD, DLY_SHORT};
					{SEQ_LARGE, 4'd4}:     {mask, val, kind} = {ACT_CLAMP, ACT_CLAMP, DLY_SHORT};
					{SEQ_LARGE, 4'd5}:     {mask, val, kind} = {ACT_LIFT2, ACT_LIFT2_L1, DLY_LONG};
					{SEQ_LARGE, 4'd6}:     {mask, val, kind} = {ACT_FWD, ACT_NONE, DLY_SHORT};
					{SEQ_LARGE, 4'd7}:     {mask, val, kind} = {ACT_LIFT1, ACT_NONE, DLY_LONG};
					{SEQ_LARGE, 4'd8}:     {mask, val, kind} = {ACT_LIFT2, ACT_NONE, DLY_LONG};
					{SEQ_LARGE, 4'd9}:     {mask, val, kind} = {ACT_CLAMP, ACT_NONE, DLY_SHORT};
					{SEQ_SMALL, 4'd1}:     {mask, val, kind} = {ACT_CLAMP, ACT_NONE, DLY_SHORT};
					{SEQ_SMALL, 4'd2}:     {mask, val, kind} = {ACT_LIFT2, ACT_LIFT2_L1, DLY_LONG};
					{SEQ_SMALL, 4'd3}:     {mask, val, kind} = {ACT_LIFT1, ACT_LIFT1_L1, DLY_LONG};
					{SEQ_SMALL, 4'd4}:     {mask, val, kind} = {ACT_FWD, ACT_FWD, DLY_SHORT};
					{SEQ_SMALL, 4'd5}:     {mask, val, kind} = {ACT_CLAMP, ACT_CLAMP, DLY_SHORT};
					{SEQ_SMALL, 4'd6}:     {mask, val, kind} = {ACT_MID, ACT_MID, DLY_SHORT};
					{SEQ_SMALL, 4'd7}:     {mask, val, kind} = {ACT_LIFT1, ACT_NONE, DLY_LONG};
					{SEQ_SMALL, 4'd8}:     {mask, val, kind} = {ACT_FWD, ACT_NONE, DLY_SHORT};
					{SEQ_SMALL, 4'd9}:     {mask, val, kind} = {ACT_MID, ACT_NONE, DLY_SHORT};
					{SEQ_SMALL, 4'd10}:    {mask, val, kind} = {ACT_LIFT2, ACT_NONE, DLY_LONG};
					{SEQ_SMALL, 4'd11}:    {mask, val, kind} = {ACT_CLAMP, ACT_NONE, DLY_SHORT};
					{SEQ_PREP, 4'd1}:      {mask, val, kind} = {ACT_CLAMP, ACT_NONE, DLY_END};
					{SEQ_PREP, 4'd2}:      {mask, val, kind} = {ACT_LIFT2, ACT_LIFT2_L1, DLY_LONG};
					{SEQ_PREP, 4'd3}:      {mask, val, kind} = {ACT_LIFT1, ACT_LIFT1_L2, DLY_LONG};
					{SEQ_PREP, 4'd4}:      {mask, val, kind} = {ACT_FWD, ACT_FWD, DLY_SHORT};
					{SEQ_PREP, 4'd5}:      {mask, val, kind} = {ACT_MID, ACT_MID, DLY_SHORT};
					{SEQ_CATCH, 4'd1}:     {mask, val, kind} = {ACT_NONE, ACT_NONE, DLY_GATE};
					{SEQ_CATCH, 4'd2}:     {mask, val, kind} = {ACT_CLAMP, ACT_CLAMP, DLY_SHORT};
					{SEQ_CATCH, 4'd3}:     {mask, val, kind} = {ACT_FWD, ACT_NONE, DLY_SHORT};
					{SEQ_CATCH, 4'd4}:     {mask, val, kind} = {ACT_LIFT1, ACT_NONE, DLY_LONG};
					{SEQ_CATCH, 4'd5}:     {mask, val, kind} = {ACT_MID, ACT_NONE, DLY_SHORT};
					{SEQ_CATCH, 4'd6}:     {mask, val, kind} = {ACT_LIFT2, ACT_NONE, DLY_LONG};
					{SEQ_CATCH, 4'd7}:     {mask, val, kind} = {ACT_CLAMP, ACT_NONE, DLY_SHORT};
					{SEQ_EXCHANGE, 4'd1}:  {mask, val, kind} = {ACT_CLAMP, ACT_CLAMP, DLY_SHORT};
					{SEQ_EXCHANGE, 4'd2}:  {mask, val, kind} = {ACT_LIFT2, ACT_LIFT2_L2, DLY_LONG};
					{SEQ_EXCHANGE, 4'd3}:  {mask, val, kind} = {ACT_LIFT1, ACT_LIFT1_L1, DLY_LONG};
					{SEQ_EXCHANGE, 4'd4}:  {mask, val, kind} = {ACT_FWD, ACT_FWD, DLY_SHORT};
					{SEQ_EXCHANGE, 4'd5}:  {mask, val, kind} = {ACT_CLAMP, ACT_NONE, DLY_SHORT};
					{SEQ_EXCHANGE, 4'd6}:  {mask, val, kind} = {ACT_EXCH, ACT_EXCH, DLY_SHORT};
					{SEQ_EXCHANGE, 4'd7}:
						{mask, val, kind} = {ACT_EXCH | ACT_FWD, ACT_NONE, DLY_SHORT};
					{SEQ_EXCHANGE, 4'd8}:  {mask, val, kind} = {ACT_LIFT1, ACT_NONE, DLY_LONG};
					{SEQ_EXCHANGE, 4'd9}:  {mask, val, kind} = {ACT_LIFT2, ACT_NONE, DLY_LONG};
					default:               {mask, val, kind} = {ACT_NONE, ACT_NONE, DLY_SHORT};
				endcase
				step_nxt[s] = k + 1'b1;
				act_bits = (act_bits & ~mask) | val;
				// catch wait: no delay until the photogate fires
				if (kind != DLY_GATE || pg) begin
					case (kind)
						DLY_LONG: t = long_ticks;
						DLY_END:  t = end_ticks;
						DLY_GATE: t = gate_ticks;
						default:  t = short_ticks;
					endcase
					arm_delay(t);
				end
			end else if (k == last_k) begin
				step_nxt[s] = 4'd0;
				mode_now = (s == SEQ_PREP) ? MODE_CATCH : MODE_IDLE;
				if (mode_now == MODE_IDLE)
					arm_delay(end_ticks);
			end else begin
				step_cur[s] = 4'd0;
				step_nxt[s] = 4'd0;
			end
		end
		shown = (mode_now != MODE_IDLE) ? step_cur[mode_now - 1'b1] : 4'd0;
		r = {act_bits, mode_now, shown, dly_run};
	endtask

	task automatic send_tick(input logic mw, input logic [2:0] mv, input logic pg,
			input logic use_fixed, input tick_result_t fixed_res);
		int           gap;
		tick_result_t r;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.mode_write <= mw;
		in_ch.mode_value <= mv;
		in_ch.photogate  <= pg;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		step_sequences(mw, mv, pg, r);
		tick_results.push_back(use_fixed ? fixed_res : r);
		ticks_sent++;
	endtask

	// stop offering and let every result drain
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (tick_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_SHORT: short_ticks = data;
			CFG_LONG:  long_ticks  = data;
			CFG_END:   end_ticks   = data;
			default:   gate_ticks  = data;
		endcase
	endtask

	function automatic logic [15:0] pick_ticks();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 16'($urandom_range(0, 3));
		else if (r < 9)
			return 16'($urandom_range(4, 20));
		return 16'($urandom_range(21, 60));
	endfunction

	function automatic row_t tick_row(input logic mw, input logic [2:0] mv, input logic pg);
		row_t r;
		r = '0;
		r.kind = ROW_TICK;
		r.mw = mw;
		r.mv = mv;
		r.pg = pg;
		return r;
	endfunction

	function automatic row_t fixed_row(input logic mw, input logic [2:0] mv, input logic pg,
			input tick_result_t res);
		row_t r;
		r = tick_row(mw, mv, pg);
		r.kind = ROW_FIXED;
		r.res = res;
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [1:0] idx, input logic [15:0] data);
		row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 100)
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// result side
	initial begin
		int           w;
		tick_result_t got;
		tick_result_t want;
		out_ch.ready = 1'b0;
		forever begin
			w = no_idle ? 0 : $urandom_range(0, 5);
			if (hold_cycles != 0) begin
				w = hold_cycles;
				hold_cycles = 0;
			end
			@(negedge clk);
			if (w > 0) begin
				out_ch.ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			got = {out_ch.exchange_on, out_ch.midair_on, out_ch.forward_on,
				out_ch.lift_twice_level, out_ch.lift_once_level, out_ch.clamp_on,
				out_ch.active_mode, out_ch.active_step, out_ch.delay_pending};
			if (tick_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 100)
					$display("%0t: transaction with nothing expected, actual %h", $time, got);
			end else begin
				want = tick_results.pop_front();
				check_field("clamp_on", 4'(want.clamp), 4'(got.clamp));
				check_field("lift_once_level", 4'(want.lift1), 4'(got.lift1));
				check_field("lift_twice_level", 4'(want.lift2), 4'(got.lift2));
				check_field("forward_on", 4'(want.fwd), 4'(got.fwd));
				check_field("midair_on", 4'(want.mid), 4'(got.mid));
				check_field("exchange_on", 4'(want.exch), 4'(got.exch));
				check_field("active_mode", 4'(want.mode), 4'(got.mode));
				check_field("active_step", want.step, got.step);
				check_field("delay_pending", 4'(want.pend), 4'(got.pend));
			end
		end
	end

	initial begin
		int           i;
		int           p;
		int           n;
		int           phase_end;
		logic         mw;
		logic [2:0]   mv;
		logic         pg;
		row_t         row;
		tick_result_t idle_res;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_SHORT;
		cfg_data         = '0;
		in_ch.valid      = 1'b0;
		in_ch.mode_write = 1'b0;
		in_ch.mode_value = MODE_IDLE;
		in_ch.photogate  = 1'b0;
		for (i = 0; i < NUM_SEQ; i++) begin
			step_cur[i] = '0;
			step_nxt[i] = '0;
		end

		idle_res = {ACT_NONE, MODE_IDLE, 4'd0, 1'b0};
		// reset values, ignored mode codes, first step
		plan.push_back(fixed_row(1'b0, MODE_IDLE, 1'b0, idle_res));
		plan.push_back(fixed_row(1'b1, MODE_BAD_HI, 1'b1, idle_res));
		plan.push_back(fixed_row(1'b1, MODE_BAD_LO, 1'b0, idle_res));
		plan.push_back(fixed_row(1'b1, MODE_LARGE, 1'b0, {ACT_NONE, MODE_LARGE, 4'd1, 1'b0}));
		plan.push_back(fixed_row(1'b1, MODE_IDLE, 1'b1, idle_res));
		plan.push_back(cfg_row(CFG_SHORT, 16'd0));
		plan.push_back(cfg_row(CFG_LONG, 16'd0));
		plan.push_back(cfg_row(CFG_END, 16'd0));
		plan.push_back(cfg_row(CFG_GATE, 16'd0));
		// catch waits for the photogate, then a mode change while a delay runs
		plan.push_back(tick_row(1'b1, MODE_CATCH, 1'b0));
		plan.push_back(tick_row(1'b0, MODE_IDLE, 1'b0));
		plan.push_back(tick_row(1'b0, MODE_IDLE, 1'b0));
		plan.push_back(tick_row(1'b0, MODE_BAD_HI, 1'b1));
		plan.push_back(tick_row(1'b0, MODE_IDLE, 1'b0));
		plan.push_back(tick_row(1'b0, MODE_IDLE, 1'b0));
		plan.push_back(tick_row(1'b1, MODE_PREP, 1'b1));
		plan.push_back(tick_row(1'b0, MODE_IDLE, 1'b0));
		plan.push_back(tick_row(1'b0, MODE_IDLE, 1'b1));
		plan.push_back(tick_row(1'b0, MODE_IDLE, 1'b0));
		plan.push_back(tick_row(1'b1, MODE_EXCHANGE, 1'b0));
		plan.push_back(tick_row(1'b0, MODE_IDLE, 1'b0));
		plan.push_back(tick_row(1'b0, MODE_IDLE, 1'b0));
		plan.push_back(tick_row(1'b0, MODE_IDLE, 1'b0));
		plan.push_back(tick_row(1'b1, MODE_SMALL, 1'b0));
		plan.push_back(tick_row(1'b0, MODE_IDLE, 1'b0));
		plan.push_back(tick_row(1'b1, MODE_SMALL, 1'b1));
		plan.push_back(tick_row(1'b0, MODE_IDLE, 1'b0));
		plan.push_back(tick_row(1'b1, MODE_LARGE, 1'b1));
		plan.push_back(tick_row(1'b0, MODE_IDLE, 1'b0));

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			case (row.kind)
				ROW_CFG: begin
					settle();
					write_reg(row.idx, row.data);
				end
				ROW_FIXED: send_tick(row.mw, row.mv, row.pg, 1'b1, row.res);
				default:   send_tick(row.mw, row.mv, row.pg, 1'b0, row.res);
			endcase
		end

		// random phases: mostly complete sequences, some stray mode writes
		for (p = 0; p < 6; p++) begin
			settle();
			no_idle = 1'b0;
			write_reg(CFG_SHORT, pick_ticks());
			write_reg(CFG_LONG, pick_ticks());
			write_reg(CFG_END, pick_ticks());
			write_reg(CFG_GATE, pick_ticks());
			if (p == 1)
				hold_cycles = 200;
			phase_end = ticks_sent + 305;
			while (ticks_sent < phase_end) begin
				no_idle = ($urandom_range(0, 3) == 0);
				send_tick(1'b1, 3'($urandom_range(MODE_LARGE, MODE_EXCHANGE)),
					1'($urandom_range(0, 1)), 1'b0, '0);
				n = 0;
				while (!(mode_now == MODE_IDLE && !dly_run) && n < 250
						&& ticks_sent < phase_end) begin
					mw = ($urandom_range(0, 49) < 2);
					mv = 3'($urandom_range(0, 7));
					if (mode_now == MODE_CATCH)
						pg = ($urandom_range(0, 3) == 0);
					else
						pg = 1'($urandom_range(0, 1));
					send_tick(mw, mv, pg, 1'b0, '0);
					n++;
				end
			end
		end

		// longest delays, held pending
		settle();
		write_reg(CFG_SHORT, DLY_MAX);
		write_reg(CFG_LONG, DLY_MAX);
		write_reg(CFG_END, DLY_MAX);
		write_reg(CFG_GATE, DLY_MAX);
		no_idle = 1'b1;
		send_tick(1'b1, MODE_LARGE, 1'b0, 1'b0, '0);
		for (i = 0; i < 40; i++)
			send_tick(1'b0, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'b0, '0);

		settle();
		if (mismatches == 0)
			$display("timed_actuator_sequencer_test OK");
		else
			$display("timed_actuator_sequencer_test NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/tas_pkg.sv
sv/tas_if.sv
sv/tas_delay_timer.sv
sv/timed_actuator_sequencer.sv
verif/timed_actuator_sequencer_test.sv
